// ===== rtl/nearest_scale_clip_address_gen_assert.svh =====
// Assertion macros used by the address generator controller.
`ifndef NEAREST_SCALE_CLIP_ADDRESS_GEN_ASSERT_SVH
`define NEAREST_SCALE_CLIP_ADDRESS_GEN_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SNCAG_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sncag assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SNCAG_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sncag assertion failed");

`endif

// ===== rtl/sncag_pkg.sv =====
// Types, constants and codes shared by the address generator modules.
package sncag_pkg;

   localparam int DIM_W      = 14;
   localparam int FLD_W      = 16;
   localparam int WRK_W      = 32;
   localparam int MUL_W      = 16;
   localparam int PROD_W     = 32;
   localparam int DIVD_W     = 30;
   localparam int DIVS_W     = 16;
   localparam int CNT_W      = 5;
   localparam int REG_IDX_W  = 3;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 64;

   typedef logic        [DIM_W-1:0] dim_type;
   typedef logic signed [FLD_W-1:0] fld_type;
   typedef logic signed [WRK_W-1:0] wrk_type;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_SRC_IMG_W = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SRC_IMG_H = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DST_IMG_W = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DST_IMG_H = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_L    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_T    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_W    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_H    = 3'd7;

   // item kinds
   localparam logic KIND_REQ   = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PIXEL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IDLE  = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CLIPA, OP_CLIPB, OP_LMUL, OP_LFIX, OP_RMUL, OP_RFIX,
      OP_TPOSTA, OP_TPOSTB, OP_OK, OP_EMPTY, OP_NOP, OP_PMUL, OP_PFIX, OP_PIX
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLIPA, ST_CLIPB, ST_TPRE, ST_LMUL, ST_LDIV, ST_TMID, ST_RMUL,
      ST_RDIV, ST_TPOSTA, ST_TPOSTB, ST_FIN, ST_PMUL, ST_PDIV, ST_PEMIT, ST_RESP
   } state_type;

   typedef struct packed {
      op_type op;
      logic   axis;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic div_done;
      logic clipa_fail;
      logic clipb_fail;
      logic pre_fail;
      logic s_neg;
      logic mid_fail;
      logic over;
      logic dw_nonpos;
      logic posta_fail;
      logic postb_fail;
   } sts_type;

endpackage

// ===== rtl/nearest_scale_clip_address_gen.sv =====
// Top level of the nearest-neighbor scaling address generator.
//
// Usage:
//   csr_*  : register writes (index 0..7, data in the low bits), always ready;
//            write only while no item is in flight.
//   req_*  : items; tuser 0 = new scale request (regions in tdata),
//            tuser 1 = ask for the next pixel address.
//   rsp_*  : one result per item; tuser is the status, tlast marks the final
//            pixel of a request.
//   One item is in flight at a time; req_tready is high only when idle, and
//   the next item can be taken in the cycle after the result is accepted.
//   A pixel item makes two passes (x then y) through the shared 30-step
//   bit-serial divider, each with launch and finish, plus one emit step.
//   A request that yields a window runs a division for each source edge
//   it trims, on either side of both axes; a request that clips to nothing answers
//   from the stage that rejects it; a pixel item with nothing pending goes
//   straight to the result.
//   When rsp_tready is low the result is held and no new item is taken.
//   Reset clears the configuration, the cursor and the active flag, drops any pending request and idles.
module nearest_scale_clip_address_gen (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h (16 bits each)
   input  logic [sncag_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_dst_x, out_dst_y, out_src_x, out_src_y (14 bits each), row_end, zero fill
   output logic [sncag_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [sncag_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sncag_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [sncag_pkg::FLD_W-1:0]          csr_data
);

   sncag_pkg::cmd_type cmd;
   sncag_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   sncag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sncag_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ===== rtl/sncag_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module sncag_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sncag_pkg::DIVD_W-1:0]  dividend,
   input  logic [sncag_pkg::DIVS_W-1:0]  divisor,
   output logic [sncag_pkg::DIVD_W-1:0]  quotient,
   output logic                          done
);

   logic [sncag_pkg::DIVD_W-1:0] q_ff, q_in;
   logic [sncag_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [sncag_pkg::DIVS_W-1:0] den_ff, den_in;
   logic [sncag_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [sncag_pkg::DIVS_W:0]   trial;
   logic [sncag_pkg::DIVS_W:0]   diff;
   logic                         ge;

   // one trial subtraction per step
   assign trial = {rem_ff, q_ff[sncag_pkg::DIVD_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = sncag_pkg::CNT_W'(sncag_pkg::DIVD_W);
      end else if (cnt_ff != '0) begin
         q_in   = {q_ff[sncag_pkg::DIVD_W-2:0], ge};
         rem_in = ge ? diff[sncag_pkg::DIVS_W-1:0] : trial[sncag_pkg::DIVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = q_ff;
   assign done     = cnt_ff == '0;

endmodule

// ===== rtl/sncag_datapath.sv =====
// Datapath: registers, clipping and trimming arithmetic, cursor and result register.
module sncag_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sncag_pkg::cmd_type                    cmd,
   input  logic [sncag_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                  csr_we,
   input  logic [sncag_pkg::REG_IDX_W-1:0]       csr_index,
   input  logic [sncag_pkg::FLD_W-1:0]           csr_data,
   output sncag_pkg::sts_type                    sts,
   output logic [sncag_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [sncag_pkg::STATUS_W-1:0]        rsp_tuser,
   output logic                                  rsp_tlast
);

   // configuration
   sncag_pkg::dim_type img_src_ff[2], img_src_in[2];
   sncag_pkg::dim_type img_dst_ff[2], img_dst_in[2];
   sncag_pkg::fld_type clip_pos_ff[2], clip_pos_in[2];
   sncag_pkg::fld_type clip_len_ff[2], clip_len_in[2];

   // per-axis working regions; index 0 is x, 1 is y
   sncag_pkg::wrk_type s_ff[2], s_in[2];
   sncag_pkg::wrk_type sw_ff[2], sw_in[2];
   sncag_pkg::wrk_type d_ff[2], d_in[2];
   sncag_pkg::wrk_type dw_ff[2], dw_in[2];
   sncag_pkg::wrk_type c_ff[2], c_in[2];
   sncag_pkg::wrk_type cw_ff[2], cw_in[2];
   sncag_pkg::dim_type samp_ff[2], samp_in[2];

   logic               active_ff, active_in;
   sncag_pkg::dim_type col_ff, col_in, row_ff, row_in;

   // result register
   logic [sncag_pkg::STATUS_W-1:0] st_ff, st_in;
   sncag_pkg::dim_type             odx_ff, odx_in, ody_ff, ody_in;
   sncag_pkg::dim_type             osx_ff, osx_in, osy_ff, osy_in;
   logic                           rend_ff, rend_in, last_ff, last_in;

   // axis-selected values
   sncag_pkg::wrk_type s_a, sw_a, d_a, dw_a, c_a, cw_a, img_s_a, img_d_a;
   sncag_pkg::wrk_type img_s[2], img_d[2];
   sncag_pkg::wrk_type ca_c[2], ca_cw[2], cb_c[2], cb_cw[2];
   sncag_pkg::wrk_type pa_c, pa_cw, pb_cw;
   logic               pa_fail1, pa_fail2;
   sncag_pkg::wrk_type pix_a, neg_s, rem_src, pix_off, quot_w;
   logic [sncag_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [sncag_pkg::PROD_W-1:0] product;
   logic [sncag_pkg::DIVS_W-1:0] divisor;
   logic                         div_start, div_done;
   logic [sncag_pkg::DIVD_W-1:0] div_quot;
   sncag_pkg::wrk_type           px, py;
   logic [sncag_pkg::DIM_W:0]    col_p1, row_p1;
   logic                         rend, fin;

   function automatic sncag_pkg::wrk_type sext16(input logic [sncag_pkg::FLD_W-1:0] v);
      return {{(sncag_pkg::WRK_W-sncag_pkg::FLD_W){v[sncag_pkg::FLD_W-1]}}, v};
   endfunction

   function automatic sncag_pkg::wrk_type zext14(input sncag_pkg::dim_type v);
      return {{(sncag_pkg::WRK_W-sncag_pkg::DIM_W){1'b0}}, v};
   endfunction

   function automatic logic spans_meet(input sncag_pkg::wrk_type a, input sncag_pkg::wrk_type aw,
                                       input sncag_pkg::wrk_type bw);
      return !((a + aw <= 0) || (bw <= a));
   endfunction

   assign img_s[0] = zext14(img_src_ff[0]);
   assign img_s[1] = zext14(img_src_ff[1]);
   assign img_d[0] = zext14(img_dst_ff[0]);
   assign img_d[1] = zext14(img_dst_ff[1]);

   assign s_a     = s_ff[cmd.axis];
   assign sw_a    = sw_ff[cmd.axis];
   assign d_a     = d_ff[cmd.axis];
   assign dw_a    = dw_ff[cmd.axis];
   assign c_a     = c_ff[cmd.axis];
   assign cw_a    = cw_ff[cmd.axis];
   assign img_s_a = img_s[cmd.axis];
   assign img_d_a = img_d[cmd.axis];

   // clip against destination image, then against destination region
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         ca_c[i]  = sext16(clip_pos_ff[i]);
         ca_cw[i] = sext16(clip_len_ff[i]);
         if (ca_c[i] < 0) begin
            ca_cw[i] = ca_cw[i] + ca_c[i];
            ca_c[i]  = '0;
         end
         if (ca_c[i] + ca_cw[i] > img_d[i]) begin
            ca_cw[i] = img_d[i] - ca_c[i];
         end
         cb_c[i]  = c_ff[i];
         cb_cw[i] = cw_ff[i];
         if (cb_c[i] < d_ff[i]) begin
            cb_cw[i] = cb_cw[i] + cb_c[i] - d_ff[i];
            cb_c[i]  = d_ff[i];
         end
         if (cb_c[i] + cb_cw[i] > d_ff[i] + dw_ff[i]) begin
            cb_cw[i] = d_ff[i] + dw_ff[i] - cb_c[i];
         end
      end
   end

   // window trim after the source region was trimmed on this axis
   always_comb begin
      pa_fail1 = (dw_a <= 0) || (sw_a <= 0);
      pa_c     = c_a;
      pa_cw    = cw_a;
      if (pa_c < 0) begin
         pa_cw = pa_cw + pa_c;
         pa_c  = '0;
      end
      pa_fail2 = (pa_cw <= 0) || (pa_c >= img_d_a);
      if (pa_c < d_a) begin
         pa_cw = pa_cw + pa_c - d_a;
         pa_c  = d_a;
      end
      pb_cw = cw_a;
      if (c_a + pb_cw > d_a + dw_a) begin
         pb_cw = d_a + dw_a - c_a;
      end
      if (c_a + pb_cw > img_d_a) begin
         pb_cw = img_d_a - c_a;
      end
   end

   // status toward the controller
   always_comb begin
      sts.active     = active_ff;
      sts.div_done   = div_done;
      sts.clipa_fail = (dw_ff[0] <= 0) || (dw_ff[1] <= 0)
                       || !spans_meet(d_ff[0], dw_ff[0], img_d[0])
                       || !spans_meet(d_ff[1], dw_ff[1], img_d[1])
                       || !spans_meet(s_ff[0], sw_ff[0], img_s[0])
                       || !spans_meet(s_ff[1], sw_ff[1], img_s[1]);
      sts.clipb_fail = (sw_ff[0] <= 0) || (sw_ff[1] <= 0) || (cb_cw[0] <= 0) || (cb_cw[1] <= 0);
      sts.pre_fail   = (sw_a <= 0) || (dw_a <= 0);
      sts.s_neg      = s_a < 0;
      sts.mid_fail   = (s_a >= img_s_a) || (sw_a <= 0);
      sts.over       = s_a + sw_a > img_s_a;
      sts.dw_nonpos  = dw_a <= 0;
      sts.posta_fail = pa_fail1 || pa_fail2;
      sts.postb_fail = pb_cw <= 0;
   end

   // multiplier operands and divider launch
   assign pix_a   = c_a + zext14(cmd.axis ? row_ff : col_ff);
   assign neg_s   = -s_a;
   assign rem_src = img_s_a - s_a;
   assign pix_off = pix_a - d_a;

   always_comb begin
      mul_a     = pix_off[sncag_pkg::MUL_W-1:0];
      mul_b     = sw_a[sncag_pkg::MUL_W-1:0];
      divisor   = dw_a[sncag_pkg::DIVS_W-1:0];
      div_start = 1'b0;
      case (cmd.op)
         sncag_pkg::OP_LMUL: begin
            mul_a     = neg_s[sncag_pkg::MUL_W-1:0];
            mul_b     = dw_a[sncag_pkg::MUL_W-1:0];
            divisor   = sw_a[sncag_pkg::DIVS_W-1:0];
            div_start = 1'b1;
         end
         sncag_pkg::OP_RMUL: begin
            mul_a     = dw_a[sncag_pkg::MUL_W-1:0];
            mul_b     = rem_src[sncag_pkg::MUL_W-1:0];
            divisor   = sw_a[sncag_pkg::DIVS_W-1:0];
            div_start = 1'b1;
         end
         sncag_pkg::OP_PMUL: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   assign product = sncag_pkg::PROD_W'(mul_a) * sncag_pkg::PROD_W'(mul_b);

   sncag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product[sncag_pkg::DIVD_W-1:0]),
      .divisor  (divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   assign quot_w = {{(sncag_pkg::WRK_W-sncag_pkg::DIVD_W){1'b0}}, div_quot};

   // current pixel and its row and frame marks
   assign px     = c_ff[0] + zext14(col_ff);
   assign py     = c_ff[1] + zext14(row_ff);
   assign col_p1 = {1'b0, col_ff} + 1'b1;
   assign row_p1 = {1'b0, row_ff} + 1'b1;
   assign rend   = $signed({{(sncag_pkg::WRK_W-sncag_pkg::DIM_W-1){1'b0}}, col_p1}) >= cw_ff[0];
   assign fin    = rend
                   && ($signed({{(sncag_pkg::WRK_W-sncag_pkg::DIM_W-1){1'b0}}, row_p1}) >= cw_ff[1]);

   // next register values
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         img_src_in[i]  = img_src_ff[i];
         img_dst_in[i]  = img_dst_ff[i];
         clip_pos_in[i] = clip_pos_ff[i];
         clip_len_in[i] = clip_len_ff[i];
         s_in[i]        = s_ff[i];
         sw_in[i]       = sw_ff[i];
         d_in[i]        = d_ff[i];
         dw_in[i]       = dw_ff[i];
         c_in[i]        = c_ff[i];
         cw_in[i]       = cw_ff[i];
         samp_in[i]     = samp_ff[i];
      end
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      st_in     = st_ff;
      odx_in    = odx_ff;
      ody_in    = ody_ff;
      osx_in    = osx_ff;
      osy_in    = osy_ff;
      rend_in   = rend_ff;
      last_in   = last_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            sncag_pkg::REG_SRC_IMG_W: img_src_in[0]  = csr_data[sncag_pkg::DIM_W-1:0];
            sncag_pkg::REG_SRC_IMG_H: img_src_in[1]  = csr_data[sncag_pkg::DIM_W-1:0];
            sncag_pkg::REG_DST_IMG_W: img_dst_in[0]  = csr_data[sncag_pkg::DIM_W-1:0];
            sncag_pkg::REG_DST_IMG_H: img_dst_in[1]  = csr_data[sncag_pkg::DIM_W-1:0];
            sncag_pkg::REG_CLIP_L:    clip_pos_in[0] = csr_data;
            sncag_pkg::REG_CLIP_T:    clip_pos_in[1] = csr_data;
            sncag_pkg::REG_CLIP_W:    clip_len_in[0] = csr_data;
            sncag_pkg::REG_CLIP_H:    clip_len_in[1] = csr_data;
         endcase
      end

      case (cmd.op)
         sncag_pkg::OP_LOAD: begin
            s_in[0]  = sext16(req_tdata[15:0]);
            s_in[1]  = sext16(req_tdata[31:16]);
            sw_in[0] = sext16(req_tdata[47:32]);
            sw_in[1] = sext16(req_tdata[63:48]);
            d_in[0]  = sext16(req_tdata[79:64]);
            d_in[1]  = sext16(req_tdata[95:80]);
            dw_in[0] = sext16(req_tdata[111:96]);
            dw_in[1] = sext16(req_tdata[127:112]);
         end
         sncag_pkg::OP_CLIPA: begin
            for (int i = 0; i < 2; i++) begin
               c_in[i]  = ca_c[i];
               cw_in[i] = ca_cw[i];
            end
         end
         sncag_pkg::OP_CLIPB: begin
            for (int i = 0; i < 2; i++) begin
               c_in[i]  = cb_c[i];
               cw_in[i] = cb_cw[i];
            end
         end
         sncag_pkg::OP_LFIX: begin
            // negative source origin: quotient is the magnitude of the shift
            d_in[cmd.axis]  = d_a + quot_w;
            dw_in[cmd.axis] = dw_a - quot_w;
            sw_in[cmd.axis] = sw_a + s_a;
            s_in[cmd.axis]  = '0;
         end
         sncag_pkg::OP_RFIX: begin
            dw_in[cmd.axis] = quot_w;
            sw_in[cmd.axis] = rem_src;
         end
         sncag_pkg::OP_TPOSTA: begin
            c_in[cmd.axis]  = pa_c;
            cw_in[cmd.axis] = pa_cw;
         end
         sncag_pkg::OP_TPOSTB: begin
            cw_in[cmd.axis] = pb_cw;
         end
         sncag_pkg::OP_PFIX: begin
            samp_in[cmd.axis] = div_quot[sncag_pkg::DIM_W-1:0] + s_a[sncag_pkg::DIM_W-1:0];
         end
         sncag_pkg::OP_OK: begin
            active_in = 1'b1;
            col_in    = '0;
            row_in    = '0;
            st_in     = sncag_pkg::STATUS_OK;
            odx_in    = '0;
            ody_in    = '0;
            osx_in    = '0;
            osy_in    = '0;
            rend_in   = 1'b0;
            last_in   = 1'b0;
         end
         sncag_pkg::OP_EMPTY: begin
            active_in = 1'b0;
            st_in     = sncag_pkg::STATUS_EMPTY;
            odx_in    = '0;
            ody_in    = '0;
            osx_in    = '0;
            osy_in    = '0;
            rend_in   = 1'b0;
            last_in   = 1'b0;
         end
         sncag_pkg::OP_NOP: begin
            st_in   = sncag_pkg::STATUS_IDLE;
            odx_in  = '0;
            ody_in  = '0;
            osx_in  = '0;
            osy_in  = '0;
            rend_in = 1'b0;
            last_in = 1'b0;
         end
         sncag_pkg::OP_PIX: begin
            st_in   = sncag_pkg::STATUS_PIXEL;
            odx_in  = px[sncag_pkg::DIM_W-1:0];
            ody_in  = py[sncag_pkg::DIM_W-1:0];
            osx_in  = samp_ff[0];
            osy_in  = samp_ff[1];
            rend_in = rend;
            last_in = fin;
            // advance the cursor in row order
            if (fin) begin
               active_in = 1'b0;
               col_in    = '0;
               row_in    = '0;
            end else if (rend) begin
               col_in = '0;
               row_in = row_p1[sncag_pkg::DIM_W-1:0];
            end else begin
               col_in = col_p1[sncag_pkg::DIM_W-1:0];
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         for (int i = 0; i < 2; i++) begin
            img_src_ff[i]  <= '0;
            img_dst_ff[i]  <= '0;
            clip_pos_ff[i] <= '0;
            clip_len_ff[i] <= '0;
         end
      end else begin
         active_ff <= active_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         for (int i = 0; i < 2; i++) begin
            img_src_ff[i]  <= img_src_in[i];
            img_dst_ff[i]  <= img_dst_in[i];
            clip_pos_ff[i] <= clip_pos_in[i];
            clip_len_ff[i] <= clip_len_in[i];
         end
      end
      for (int i = 0; i < 2; i++) begin
         s_ff[i]    <= s_in[i];
         sw_ff[i]   <= sw_in[i];
         d_ff[i]    <= d_in[i];
         dw_ff[i]   <= dw_in[i];
         c_ff[i]    <= c_in[i];
         cw_ff[i]   <= cw_in[i];
         samp_ff[i] <= samp_in[i];
      end
      st_ff   <= st_in;
      odx_ff  <= odx_in;
      ody_ff  <= ody_in;
      osx_ff  <= osx_in;
      osy_ff  <= osy_in;
      rend_ff <= rend_in;
      last_ff <= last_in;
   end

   assign rsp_tdata = {{(sncag_pkg::RSP_DATA_W-4*sncag_pkg::DIM_W-1){1'b0}},
                       rend_ff, osy_ff, osx_ff, ody_ff, odx_ff};
   assign rsp_tuser = st_ff;
   assign rsp_tlast = last_ff;

endmodule

// ===== rtl/sncag_ctrl.sv =====
// Controller: sequences setup, per-pixel division and the result handshake.
`include "nearest_scale_clip_address_gen_assert.svh"

module sncag_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tuser,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  sncag_pkg::sts_type  sts,
   output sncag_pkg::cmd_type  cmd
);

   sncag_pkg::state_type state_ff, state_in;
   logic                 axis_ff, axis_in;

   // next state and axis
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         sncag_pkg::ST_IDLE: begin
            axis_in = 1'b0;
            if (req_tvalid) begin
               if (req_tuser == sncag_pkg::KIND_REQ) state_in = sncag_pkg::ST_CLIPA;
               else if (sts.active)                  state_in = sncag_pkg::ST_PMUL;
               else                                  state_in = sncag_pkg::ST_RESP;
            end
         end
         sncag_pkg::ST_CLIPA:
            state_in = sts.clipa_fail ? sncag_pkg::ST_RESP : sncag_pkg::ST_CLIPB;
         sncag_pkg::ST_CLIPB:
            state_in = sts.clipb_fail ? sncag_pkg::ST_RESP : sncag_pkg::ST_TPRE;
         sncag_pkg::ST_TPRE: begin
            if (sts.pre_fail)   state_in = sncag_pkg::ST_RESP;
            else if (sts.s_neg) state_in = sncag_pkg::ST_LMUL;
            else                state_in = sncag_pkg::ST_TMID;
         end
         sncag_pkg::ST_LMUL: state_in = sncag_pkg::ST_LDIV;
         sncag_pkg::ST_LDIV: if (sts.div_done) state_in = sncag_pkg::ST_TMID;
         sncag_pkg::ST_TMID: begin
            if (sts.mid_fail)                   state_in = sncag_pkg::ST_RESP;
            else if (sts.over && sts.dw_nonpos) state_in = sncag_pkg::ST_RESP;
            else if (sts.over)                  state_in = sncag_pkg::ST_RMUL;
            else                                state_in = sncag_pkg::ST_TPOSTA;
         end
         sncag_pkg::ST_RMUL: state_in = sncag_pkg::ST_RDIV;
         sncag_pkg::ST_RDIV: if (sts.div_done) state_in = sncag_pkg::ST_TPOSTA;
         sncag_pkg::ST_TPOSTA:
            state_in = sts.posta_fail ? sncag_pkg::ST_RESP : sncag_pkg::ST_TPOSTB;
         sncag_pkg::ST_TPOSTB: begin
            if (sts.postb_fail) begin
               state_in = sncag_pkg::ST_RESP;
            end else if (axis_ff) begin
               state_in = sncag_pkg::ST_FIN;
            end else begin
               state_in = sncag_pkg::ST_TPRE;
               axis_in  = 1'b1;
            end
         end
         sncag_pkg::ST_FIN:  state_in = sncag_pkg::ST_RESP;
         sncag_pkg::ST_PMUL: state_in = sncag_pkg::ST_PDIV;
         sncag_pkg::ST_PDIV: begin
            if (sts.div_done) begin
               if (axis_ff) begin
                  state_in = sncag_pkg::ST_PEMIT;
               end else begin
                  state_in = sncag_pkg::ST_PMUL;
                  axis_in  = 1'b1;
               end
            end
         end
         sncag_pkg::ST_PEMIT: state_in = sncag_pkg::ST_RESP;
         sncag_pkg::ST_RESP:  if (rsp_tready) state_in = sncag_pkg::ST_IDLE;
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd.op     = sncag_pkg::OP_NONE;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         sncag_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == sncag_pkg::KIND_REQ) cmd.op = sncag_pkg::OP_LOAD;
               else if (!sts.active)                 cmd.op = sncag_pkg::OP_NOP;
            end
         end
         sncag_pkg::ST_CLIPA:
            cmd.op = sts.clipa_fail ? sncag_pkg::OP_EMPTY : sncag_pkg::OP_CLIPA;
         sncag_pkg::ST_CLIPB:
            cmd.op = sts.clipb_fail ? sncag_pkg::OP_EMPTY : sncag_pkg::OP_CLIPB;
         sncag_pkg::ST_TPRE:
            if (sts.pre_fail) cmd.op = sncag_pkg::OP_EMPTY;
         sncag_pkg::ST_LMUL: cmd.op = sncag_pkg::OP_LMUL;
         sncag_pkg::ST_LDIV: if (sts.div_done) cmd.op = sncag_pkg::OP_LFIX;
         sncag_pkg::ST_TMID:
            if (sts.mid_fail || (sts.over && sts.dw_nonpos)) cmd.op = sncag_pkg::OP_EMPTY;
         sncag_pkg::ST_RMUL: cmd.op = sncag_pkg::OP_RMUL;
         sncag_pkg::ST_RDIV: if (sts.div_done) cmd.op = sncag_pkg::OP_RFIX;
         sncag_pkg::ST_TPOSTA:
            cmd.op = sts.posta_fail ? sncag_pkg::OP_EMPTY : sncag_pkg::OP_TPOSTA;
         sncag_pkg::ST_TPOSTB:
            cmd.op = sts.postb_fail ? sncag_pkg::OP_EMPTY : sncag_pkg::OP_TPOSTB;
         sncag_pkg::ST_FIN:   cmd.op = sncag_pkg::OP_OK;
         sncag_pkg::ST_PMUL:  cmd.op = sncag_pkg::OP_PMUL;
         sncag_pkg::ST_PDIV:  if (sts.div_done) cmd.op = sncag_pkg::OP_PFIX;
         sncag_pkg::ST_PEMIT: cmd.op = sncag_pkg::OP_PIX;
         sncag_pkg::ST_RESP:  rsp_tvalid = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sncag_pkg::ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   // a pixel item with nothing pending is answered at once
   `SNCAG_ASSERT_NXT(a_idle_pixel, clock, reset,
      req_tvalid && req_tready && (req_tuser == sncag_pkg::KIND_PIXEL) && !sts.active,
      state_ff == sncag_pkg::ST_RESP)

   // a stalled result stays offered
   `SNCAG_ASSERT_NXT(a_resp_hold, clock, reset,
      (state_ff == sncag_pkg::ST_RESP) && !rsp_tready, state_ff == sncag_pkg::ST_RESP)

   // every launch restarts the divider
   `SNCAG_ASSERT_NXT(a_div_launch, clock, reset,
      (state_ff == sncag_pkg::ST_LMUL) || (state_ff == sncag_pkg::ST_RMUL)
      || (state_ff == sncag_pkg::ST_PMUL), !sts.div_done)

   // input is only taken with no result pending
   `SNCAG_ASSERT_IMP(a_one_item, clock, reset, rsp_tvalid, !req_tready)

endmodule
